FILE: sv/esb_pkg.sv
// Shared types, constants and helper functions for the encoder speed estimator.
// Holds the sequencer state and op encodings, the multiplier request/response
// structs, the Q3.44 biquad coefficient tables and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none

package esb_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPD_GO,
        S_SPD_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_FOLD,
        S_ABS,
        S_OUT
    } t_state;

    // Products taken per biquad stage, in issue order
    typedef enum logic [2:0] {
        OP_B0,
        OP_B1,
        OP_A1,
        OP_B2,
        OP_A2
    } t_op;

    typedef enum logic {
        MODE_RAW,
        MODE_Q44
    } t_mul_mode;

    typedef struct packed {
        logic                start;
        t_mul_mode           mode;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic                neg;
        logic [63:0]         raw;   // low 64 bits of |a|*|b|
        logic signed [63:0]  q44;   // (a*b) >> 44, rounded, saturated
    } t_mul_rsp;

    localparam int MAX_STAGES = 4;

    localparam logic signed [63:0] COEF_ONE = 64'sd17592186044416;
    localparam logic signed [63:0] COEF_TWO = 64'sd35184372088832;

    // Stages past the second pass the signal through
    localparam logic signed [63:0] COEF_B0 [MAX_STAGES] =
        '{64'sd424605, COEF_ONE, COEF_ONE, COEF_ONE};
    localparam logic signed [63:0] COEF_B1 [MAX_STAGES] =
        '{64'sd849210, COEF_TWO, 64'sd0, 64'sd0};
    localparam logic signed [63:0] COEF_B2 [MAX_STAGES] =
        '{64'sd424605, COEF_ONE, 64'sd0, 64'sd0};
    localparam logic signed [63:0] COEF_A1 [MAX_STAGES] =
        '{64'sd34375131530789, 64'sd34837806023757, 64'sd0, 64'sd0};
    localparam logic signed [63:0] COEF_A2 [MAX_STAGES] =
        '{-64'sd16793852641720, -64'sd17257054900270, 64'sd0, 64'sd0};

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic signed [63:0] coef_get(input logic [1:0] stg, input t_op op);
        logic signed [63:0] c;
        case (op)
            OP_B0:   c = COEF_B0[stg];
            OP_B1:   c = COEF_B1[stg];
            OP_A1:   c = COEF_A1[stg];
            OP_B2:   c = COEF_B2[stg];
            OP_A2:   c = COEF_A2[stg];
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // Signed 32-bit value from sign and magnitude, saturated
    function automatic logic signed [31:0] sat32_mag(input logic neg, input logic [63:0] m);
        logic signed [31:0] r;
        if (neg) begin
            if (m >= 64'h0000_0000_8000_0000) r = S32_MIN;
            else                              r = 32'sd0 - $signed(m[31:0]);
        end else begin
            if (m > 64'h0000_0000_7FFF_FFFF) r = S32_MAX;
            else                             r = $signed(m[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/encoder_speed_estimator_biquad.sv
// Encoder speed estimator: wrap-safe counter difference, 32-bit position count,
// instant speed = delta * speed_gain (Q16.16), then a cascade of NUM_STAGES
// transposed direct-form-II lowpass biquads with Q3.44 coefficients and 64-bit
// state. One transaction in gives one transaction out. All products run through
// one shared multiplier (esb_mul) built on a single 32x32 unit. A result is formed
// from one speed product, then five products and one fold step per stage, then the
// magnitude step and the output register. The input is stalled until the sequencer
// is idle again, so a new transaction is not taken before the last one is through;
// a finished result may still wait for the sink, which holds the sequencer in its
// output state.
// Depends on esb_pkg and esb_mul.
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_estimator_biquad import esb_pkg::*; #(
    parameter int NUM_STAGES   = 2,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [31:0]             i_cfg_wdata,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [COUNTER_BITS-1:0] i_counter_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [31:0]           o_position_count,
    output logic signed [31:0]           o_filtered_speed
);

    localparam int SW      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int NDLY    = 2 * NUM_STAGES;
    localparam int DW      = $clog2(NDLY);
    localparam logic [31:0] GAIN_RST = 32'd65536;
    localparam logic [63:0] OUT_RND  = 64'd1 << 27;
    localparam logic [SW-1:0] STAGE_LAST = SW'(NUM_STAGES - 1);

    t_state                   r_state, n_state;
    logic [31:0]              r_gain;
    logic [COUNTER_BITS-1:0]  r_last, n_last;
    logic [COUNTER_BITS-1:0]  r_delta, n_delta;
    logic [31:0]              r_pos, n_pos;
    logic signed [63:0]       r_x, n_x;
    logic signed [63:0]       r_y, n_y;
    logic signed [63:0]       r_acc, n_acc;
    logic [SW-1:0]            r_stage, n_stage;
    t_op                      r_op, n_op;
    logic signed [63:0]       r_dly [NDLY];
    logic                     r_out_valid, n_out_valid;
    logic signed [31:0]       r_out_pos, n_out_pos;
    logic signed [31:0]       r_out_speed, n_out_speed;

    t_mul_req                 mul_req;
    t_mul_rsp                 mul_rsp;

    logic                     in_acc;
    logic                     out_free;
    logic                     last_stage;
    logic [COUNTER_BITS-1:0]  diff;
    logic [DW-1:0]            rd_idx;
    logic signed [63:0]       dly_rd;
    logic                     dly_we;
    logic                     dly_wbit;
    logic [DW-1:0]            wr_idx;
    logic signed [63:0]       dly_wdata;
    logic signed [31:0]       spd_inst;
    logic [63:0]              rnd_sum;
    logic signed [31:0]       spd_fin;

    esb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_stage = (r_stage == STAGE_LAST);
    assign diff       = i_counter_value - r_last;

    // d0 of the stage is read for the output sum, d1 when folding into d0
    assign rd_idx = DW'({r_stage, (r_state == S_FOLD)});
    assign dly_rd = r_dly[rd_idx];
    assign wr_idx = DW'({r_stage, dly_wbit});

    assign spd_inst = sat32_mag(mul_rsp.neg, mul_rsp.raw);
    assign rnd_sum  = $unsigned(r_acc) + OUT_RND;
    assign spd_fin  = sat32_mag(r_x[63], {28'd0, rnd_sum[63:28]});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc) n_state = S_SPD_GO;
            S_SPD_GO:   n_state = S_SPD_WAIT;
            S_SPD_WAIT: if (mul_rsp.done) n_state = S_MUL_GO;
            S_MUL_GO:   n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    if (r_op == OP_A1)                    n_state = S_FOLD;
                    else if (r_op == OP_A2 && last_stage) n_state = S_ABS;
                    else                                  n_state = S_MUL_GO;
                end
            end
            S_FOLD:     n_state = S_MUL_GO;
            S_ABS:      n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        n_last      = r_last;
        n_delta     = r_delta;
        n_pos       = r_pos;
        n_x         = r_x;
        n_y         = r_y;
        n_acc       = r_acc;
        n_stage     = r_stage;
        n_op        = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pos   = r_out_pos;
        n_out_speed = r_out_speed;
        dly_we      = 1'b0;
        dly_wbit    = 1'b0;
        dly_wdata   = sat_add64(r_acc, mul_rsp.q44);
        mul_req.start = 1'b0;
        mul_req.mode  = MODE_Q44;
        mul_req.a     = coef_get(2'(r_stage), r_op);
        mul_req.b     = (r_op == OP_A1 || r_op == OP_A2) ? r_y : r_x;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last  = i_counter_value;
                    n_delta = diff;
                    n_pos   = r_pos + 32'($signed(diff));
                end
            end
            S_SPD_GO: begin
                mul_req.start = 1'b1;
                mul_req.mode  = MODE_RAW;
                mul_req.a     = 64'($signed(r_delta));
                mul_req.b     = $signed({32'd0, r_gain});
            end
            S_SPD_WAIT: begin
                if (mul_rsp.done) begin
                    // Q16.16 speed into the Q20.44 filter domain
                    n_x     = {{4{spd_inst[31]}}, spd_inst, 28'd0};
                    n_stage = '0;
                    n_op    = OP_B0;
                end
            end
            S_MUL_GO: begin
                mul_req.start = 1'b1;
            end
            S_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    case (r_op)
                        OP_B0: begin
                            n_y  = sat_add64(mul_rsp.q44, dly_rd);
                            n_op = OP_B1;
                        end
                        OP_B1: begin
                            n_acc = mul_rsp.q44;
                            n_op  = OP_A1;
                        end
                        OP_A1: begin
                            n_acc = sat_add64(r_acc, mul_rsp.q44);
                        end
                        OP_B2: begin
                            n_acc = mul_rsp.q44;
                            n_op  = OP_A2;
                        end
                        OP_A2: begin
                            dly_we   = 1'b1;
                            dly_wbit = 1'b1;
                            n_x      = r_y;
                            n_op     = OP_B0;
                            if (!last_stage) n_stage = SW'(r_stage + 1'b1);
                        end
                        default: ;
                    endcase
                end
            end
            S_FOLD: begin
                dly_we    = 1'b1;
                dly_wbit  = 1'b0;
                dly_wdata = sat_add64(r_acc, dly_rd);
                n_op      = OP_B2;
            end
            S_ABS: begin
                n_acc = r_x[63] ? (64'sd0 - r_x) : r_x;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = $signed(r_pos);
                    n_out_speed = spd_fin;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_RST;
            r_last      <= '0;
            r_pos       <= '0;
            r_stage     <= '0;
            r_op        <= OP_B0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NDLY; i++) begin
                r_dly[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_pos       <= n_pos;
            r_stage     <= n_stage;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (dly_we) begin
                r_dly[wr_idx] <= dly_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta     <= n_delta;
        r_x         <= n_x;
        r_y         <= n_y;
        r_acc       <= n_acc;
        r_out_pos   <= n_out_pos;
        r_out_speed <= n_out_speed;
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_count = r_out_pos;
    assign o_filtered_speed = r_out_speed;

    // A product may only complete while the sequencer is waiting on it
    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_SPD_WAIT || r_state == S_MUL_WAIT))
        else $error("multiplier finished outside a wait state");

    // An accepted transaction always starts with the speed product
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SPD_GO))
        else $error("accepted transaction did not start the speed product");

    // A new result only appears from the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output valid raised outside the output state");

endmodule

`default_nettype wire

FILE: sv/esb_mul.sv
// Shared sign-magnitude 64x64 multiplier built on one 32x32 multiplier.
// Four partial products are accumulated into a 128-bit register; the result
// comes out raw or rounded to Q44 with saturation. Uses esb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esb_mul import esb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam logic [2:0] PART_LAST = 3'd3;
    localparam logic [2:0] MUL_LAST  = 3'd5;
    localparam logic [127:0] RND_HALF = 128'h1 << 43;

    logic               r_busy;
    logic               r_done;
    logic               r_pv;
    logic [2:0]         r_cnt;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [1:0]         r_off;
    logic [127:0]       r_acc;
    logic signed [63:0] r_q44;

    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [63:0]        part_prod;
    logic [1:0]         part_off;
    logic [127:0]       addend;
    logic               q_sat;
    logic [63:0]        q_mag;
    logic signed [63:0] q_next;

    // Partial order: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_half    = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_half    = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign part_prod = 64'(a_half) * 64'(b_half);
    assign part_off  = {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0]};

    always_comb begin
        case (r_off)
            2'd0:    addend = {64'd0, r_prod};
            2'd1:    addend = {32'd0, r_prod, 32'd0};
            2'd2:    addend = {r_prod, 64'd0};
            default: addend = '0;
        endcase
    end

    // Rounding half was preloaded into the accumulator
    assign q_sat  = |r_acc[127:107];
    assign q_mag  = q_sat ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, r_acc[106:44]};
    assign q_next = r_neg ? (64'sd0 - $signed(q_mag)) : $signed(q_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_pv  <= (r_cnt <= PART_LAST);
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a[63] ? 64'(64'sd0 - i_req.a) : i_req.a;
            r_b   <= i_req.b[63] ? 64'(64'sd0 - i_req.b) : i_req.b;
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_acc <= (i_req.mode == MODE_Q44) ? RND_HALF : '0;
        end else if (r_busy) begin
            if (r_cnt <= PART_LAST) begin
                r_prod <= part_prod;
                r_off  <= part_off;
            end
            if (r_pv) begin
                r_acc <= r_acc + addend;
            end
            if (r_cnt == MUL_LAST) begin
                r_q44 <= q_next;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.raw  = r_acc[63:0];
    assign o_rsp.q44  = r_q44;

endmodule

`default_nettype wire
